### rtl/bbe_pkg.sv
// Package for the edge-aware 3x3 box blur.
// Queue entry type, back-end state codes and shared constants; no dependencies.
`default_nettype none
package bbe_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int CFG_W_BITS    = 11;
  localparam int CFG_H_BITS    = 13;
  localparam int HEIGHT_LIMIT  = 4096;
  localparam int PIX_W         = 24;
  localparam int Q_DEPTH       = 4;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;
  localparam logic OP_PIXEL   = 1'b0;
  localparam logic OP_DRAIN   = 1'b1;

  localparam logic [2:0] ADDR_WIDTH  = 3'd0;
  localparam logic [2:0] ADDR_HEIGHT = 3'd4;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             emit;
    logic             top;
    logic             bot;
    logic             left;
    logic             right;
    logic             last;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    B_IDLE,
    B_LOAD,
    B_SUM,
    B_DIV,
    B_OUT
  } back_state_t;

endpackage
`default_nettype wire

### rtl/bbe_front.sv
// Front end: accepts words, tracks input and output positions, classifies.
// Depends on bbe_pkg.
`default_nettype none
module bbe_front #(
  parameter int MAX_WIDTH = bbe_pkg::MAX_WIDTH_DEF,
  parameter int CW = 10,
  parameter int WW = 11
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 restart,
  input  wire logic [WW-1:0]        width_eff,
  input  wire logic [bbe_pkg::CFG_H_BITS-1:0] height_eff,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [23:0]          s_tdata,   // blue, green, red
  input  wire logic                 s_tuser,   // op
  input  wire logic                 q_full,
  output logic                      q_push,
  output logic [CW-1:0]             q_col,
  output bbe_pkg::entry_t           q_ent
);

  localparam int HW = bbe_pkg::CFG_H_BITS;

  logic [CW-1:0] in_column, out_column;
  logic [HW-1:0] in_row, out_row;
  logic [WW-1:0] icol_inc, ocol_inc;
  logic [HW:0]   orow_inc;
  logic          pixel_phase, emit, last;

  assign pixel_phase = in_row < height_eff;
  assign s_tready    = !q_full;
  assign q_push      = s_tvalid && s_tready && !(pixel_phase && s_tuser != bbe_pkg::OP_PIXEL);

  assign icol_inc = WW'(in_column) + WW'(1);
  assign ocol_inc = WW'(out_column) + WW'(1);
  assign orow_inc = {1'b0, out_row} + (HW+1)'(1);
  assign emit = (in_row >= HW'(2)) || (in_row == HW'(1) && in_column != '0);
  assign last = (orow_inc >= {1'b0, height_eff}) && (ocol_inc >= width_eff);

  always_comb begin
    q_col       = in_column;
    q_ent.pixel = pixel_phase ? {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]} : '0;
    q_ent.emit  = emit;
    q_ent.top   = out_row == '0;
    q_ent.bot   = orow_inc >= {1'b0, height_eff};
    q_ent.left  = out_column == '0;
    q_ent.right = ocol_inc >= width_eff;
    q_ent.last  = last;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else if (q_push) begin
      if (emit && last) begin
        in_column  <= '0;
        in_row     <= '0;
        out_column <= '0;
        out_row    <= '0;
      end else begin
        if (icol_inc >= width_eff) begin
          in_column <= '0;
          in_row    <= in_row + HW'(1);
        end else begin
          in_column <= CW'(icol_inc);
        end
        if (emit) begin
          if (ocol_inc >= width_eff) begin
            out_column <= '0;
            out_row    <= out_row + HW'(1);
          end else begin
            out_column <= CW'(ocol_inc);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

### rtl/bbe_queue.sv
// Short word queue between front and back end.
// Depends on bbe_pkg.
`default_nettype none
module bbe_queue #(
  parameter int DATA_W = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] wdata,
  output logic                   full,
  input  wire logic              pop,
  output logic                   valid,
  output logic [DATA_W-1:0]      rdata
);

  localparam int AW = $clog2(bbe_pkg::Q_DEPTH);

  logic [DATA_W-1:0] slots [bbe_pkg::Q_DEPTH];
  logic [AW-1:0]     wr_ptr, rd_ptr;
  logic [AW:0]       count;

  assign full  = count == (AW+1)'(bbe_pkg::Q_DEPTH);
  assign valid = count != '0;
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + AW'(1);
      if (pop)  rd_ptr <= rd_ptr + AW'(1);
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

### rtl/bbe_back.sv
// Back end: line stores, 3x3 window, masked sums, rounding divider, output register.
// Depends on bbe_pkg.
`default_nettype none
module bbe_back #(
  parameter int MAX_WIDTH = bbe_pkg::MAX_WIDTH_DEF,
  parameter int CW = 10
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  output logic                 q_pop,
  input  wire logic [CW-1:0]   q_col,
  input  wire bbe_pkg::entry_t q_ent,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [23:0]          m_tdata,   // blue, green, red
  output logic                 m_tlast    // frame_last
);

  localparam int PW = bbe_pkg::PIX_W;

  bbe_pkg::back_state_t state, state_next;
  bbe_pkg::entry_t      cur;
  logic [CW-1:0]        cur_col;
  logic [PW-1:0]        upper_mem  [MAX_WIDTH];
  logic [PW-1:0]        middle_mem [MAX_WIDTH];
  logic [PW-1:0]        rd_upper, rd_middle;
  logic [PW-1:0]        win [9];
  logic [12:0]          rem [3];
  logic [7:0]           quo [3];
  logic [12:0]          dsh;
  logic [2:0]           step;
  logic                 out_load;
  logic [11:0]          sum_c [3];
  logic [3:0]           cnt_c;

  always_comb begin
    state_next = state;
    case (state)
      bbe_pkg::B_IDLE: if (q_valid) state_next = bbe_pkg::B_LOAD;
      bbe_pkg::B_LOAD: state_next = cur.emit ? bbe_pkg::B_SUM : bbe_pkg::B_IDLE;
      bbe_pkg::B_SUM:  state_next = bbe_pkg::B_DIV;
      bbe_pkg::B_DIV:  if (step == 3'd7) state_next = bbe_pkg::B_OUT;
      bbe_pkg::B_OUT:  if (!m_tvalid || m_tready) state_next = bbe_pkg::B_IDLE;
      default:         state_next = bbe_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = (state == bbe_pkg::B_IDLE) && q_valid;
    out_load = (state == bbe_pkg::B_OUT) && (!m_tvalid || m_tready);
  end

  // masked neighbourhood sums
  always_comb begin
    for (int k = 0; k < 3; k++) sum_c[k] = '0;
    cnt_c = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (!((r == 0 && cur.top) || (r == 2 && cur.bot) ||
              (c == 0 && cur.left) || (c == 2 && cur.right))) begin
          sum_c[0] = sum_c[0] + 12'(win[r*3+c][23:16]);
          sum_c[1] = sum_c[1] + 12'(win[r*3+c][15:8]);
          sum_c[2] = sum_c[2] + 12'(win[r*3+c][7:0]);
          cnt_c    = cnt_c + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_upper  <= upper_mem[q_col];
      rd_middle <= middle_mem[q_col];
    end
    if (state == bbe_pkg::B_LOAD) begin
      upper_mem[cur_col]  <= rd_middle;
      middle_mem[cur_col] <= cur.pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bbe_pkg::B_IDLE;
      m_tvalid <= 1'b0;
      for (int i = 0; i < 9; i++) win[i] <= '0;
    end else begin
      state <= state_next;
      if (state == bbe_pkg::B_LOAD) begin
        for (int r = 0; r < 3; r++) begin
          win[r*3]   <= win[r*3+1];
          win[r*3+1] <= win[r*3+2];
        end
        win[2] <= rd_upper;
        win[5] <= rd_middle;
        win[8] <= cur.pixel;
      end
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur     <= q_ent;
      cur_col <= q_col;
    end
    case (state)
      bbe_pkg::B_SUM: begin
        for (int k = 0; k < 3; k++) begin
          rem[k] <= {sum_c[k], 1'b0} + 13'(cnt_c);
          quo[k] <= '0;
        end
        dsh  <= {3'b0, cnt_c, 1'b0, 5'b0} << 2;
        step <= '0;
      end
      bbe_pkg::B_DIV: begin
        for (int k = 0; k < 3; k++) begin
          if (rem[k] >= dsh) begin
            rem[k] <= rem[k] - dsh;
            quo[k] <= {quo[k][6:0], 1'b1};
          end else begin
            quo[k] <= {quo[k][6:0], 1'b0};
          end
        end
        dsh  <= dsh >> 1;
        step <= step + 3'd1;
      end
      default: ;
    endcase
    if (out_load) begin
      m_tdata <= {quo[2], quo[1], quo[0]};
      m_tlast <= cur.last;
    end
  end

endmodule
`default_nettype wire

### rtl/box_blur_3x3_edge_aware.sv
// Top level of the edge-aware 3x3 box blur: config registers, front, queue, back.
// Depends on bbe_pkg, bbe_front, bbe_queue, bbe_back.
//
// channel   direction  contents
// s_*       in         pixel or drain word; tuser = op
// m_*       out        blurred pixel; tlast = frame_last
// APB       in/out     frame_width at 0x0, frame_height at 0x4
//
// Front takes one word a cycle while the queue has room.
// Back takes the next word only from idle; a word without result passes line store read and window,
// one with a result also sums, 8-step divider and output load: the divider sets the rate.
// Synchronous reset clears control state; line stores are not cleared.
// Output stalls hold the back end in its output step; the queue absorbs four words.
`default_nettype none
module box_blur_3x3_edge_aware #(
  parameter int MAX_WIDTH = bbe_pkg::MAX_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // in_blue, in_green, in_red
  input  wire logic        s_tuser,   // op
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // out_blue, out_green, out_red
  output logic             m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = bbe_pkg::CFG_H_BITS;
  localparam int QW = CW + bbe_pkg::ENTRY_W;

  logic [bbe_pkg::CFG_W_BITS-1:0] frame_width;
  logic [HW-1:0]                  frame_height;
  logic [WW-1:0]                  width_eff;
  logic [HW-1:0]                  height_eff;
  logic                           cfg_wr;
  logic                           q_push, q_full, q_pop, q_valid;
  logic [CW-1:0]                  f_col, b_col;
  bbe_pkg::entry_t                f_ent, b_ent;
  logic [QW-1:0]                  q_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == bbe_pkg::REG_HEIGHT) ? 32'(frame_height) : 32'(frame_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bbe_pkg::CFG_W_BITS'(1);
      frame_height <= HW'(1);
    end else if (cfg_wr) begin
      if (paddr[2] == bbe_pkg::REG_WIDTH) frame_width <= pwdata[bbe_pkg::CFG_W_BITS-1:0];
      else frame_height <= pwdata[HW-1:0];
    end
  end

  always_comb begin
    if (frame_width == '0) width_eff = WW'(1);
    else if (32'(frame_width) > 32'(MAX_WIDTH)) width_eff = WW'(MAX_WIDTH);
    else width_eff = WW'(frame_width);
    if (frame_height == '0) height_eff = HW'(1);
    else if (32'(frame_height) > 32'(bbe_pkg::HEIGHT_LIMIT))
      height_eff = HW'(bbe_pkg::HEIGHT_LIMIT);
    else height_eff = frame_height;
  end

  bbe_front #(.MAX_WIDTH(MAX_WIDTH), .CW(CW), .WW(WW)) u_front (
    .clk, .rst, .restart(cfg_wr), .width_eff, .height_eff,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .q_full, .q_push, .q_col(f_col), .q_ent(f_ent)
  );

  bbe_queue #(.DATA_W(QW)) u_queue (
    .clk, .rst, .push(q_push), .wdata({f_col, f_ent}), .full(q_full),
    .pop(q_pop), .valid(q_valid), .rdata(q_rdata)
  );

  assign b_col = q_rdata[QW-1:bbe_pkg::ENTRY_W];
  assign b_ent = q_rdata[bbe_pkg::ENTRY_W-1:0];

  bbe_back #(.MAX_WIDTH(MAX_WIDTH), .CW(CW)) u_back (
    .clk, .rst, .q_valid, .q_pop, .q_col(b_col), .q_ent(b_ent),
    .m_tvalid, .m_tready, .m_tdata, .m_tlast
  );

endmodule
`default_nettype wire

### rtl/bbe_check.sv
// Port-level checks for the box blur, bound to the top level.
// Depends on box_blur_3x3_edge_aware ports only.
`default_nettype none
module bbe_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata,
  input wire logic        m_tlast,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [2:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata,
  input wire logic        pready
);

  a_rst_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("word out after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled word changed");

  a_wr_read: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && paddr[2] == 1'b0 |=>
      paddr[2] != 1'b0 || prdata[10:0] == $past(pwdata[10:0]))
    else $error("width readback mismatch");

  a_hgt_read: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && paddr[2] == 1'b1 |=>
      paddr[2] != 1'b1 || prdata[12:0] == $past(pwdata[12:0]))
    else $error("height readback mismatch");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind box_blur_3x3_edge_aware bbe_check u_check (.*);
`default_nettype wire

### tb/sv/box_blur_3x3_edge_aware_tb.sv
// Testbench for box_blur_3x3_edge_aware: random and directed frames on the stream ports,
// predicted by an in-bench blur model and checked word by word. Depends on bbe_pkg and the RTL.
`timescale 1ns / 100ps
module box_blur_3x3_edge_aware_tb;

  localparam int MAXW = 1024;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic       op;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } blur_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0, s_tready, s_tuser = 1'b0;
  logic [23:0] s_tdata = '0;
  logic m_tvalid, m_tready = 1'b0, m_tlast;
  logic [23:0] m_tdata;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0, pready;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;

  box_blur_3x3_edge_aware u_top (.*);

  always #5 clk = ~clk;

  // blur model state
  logic [10:0] cfg_width;
  logic [12:0] cfg_height;
  logic [23:0] line_up [MAXW];
  logic [23:0] line_mid [MAXW];
  logic [23:0] win [3][3];
  int unsigned icol, irow, ocol, orow;

  pix_word_t  pending_words[$];
  blur_word_t expected_blur[$];
  int errors = 0, n_in = 0, n_out = 0, n_last = 0, idle_cycles = 0;
  bit hold_off = 0;

  function automatic int unsigned eff_w();
    if (cfg_width == 0) return 1;
    if (cfg_width > MAXW) return MAXW;
    return cfg_width;
  endfunction

  function automatic int unsigned eff_h();
    if (cfg_height == 0) return 1;
    if (cfg_height > 4096) return 4096;
    return cfg_height;
  endfunction

  task automatic restart_counts();
    icol = 0; irow = 0; ocol = 0; orow = 0;
  endtask

  task automatic predict_blur(input pix_word_t wd);
    int unsigned w, h, col, sr, sg, sb, n;
    logic [23:0] px, v;
    bit emit;
    blur_word_t bw;
    w = eff_w();
    h = eff_h();
    if (irow >= h) px = '0;
    else if (wd.op == bbe_pkg::OP_PIXEL) px = {wd.red, wd.green, wd.blue};
    else return;
    col = (icol >= MAXW) ? MAXW - 1 : icol;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = line_up[col];
    win[1][2] = line_mid[col];
    win[2][2] = px;
    line_up[col] = line_mid[col];
    line_mid[col] = px;
    emit = (irow >= 2) || (irow == 1 && icol >= 1);
    icol++;
    if (icol >= w) begin
      icol = 0;
      irow++;
    end
    if (!emit) return;
    sr = 0; sg = 0; sb = 0; n = 0;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) begin
        if (r == 0 && orow == 0) continue;
        if (r == 2 && orow + 1 >= h) continue;
        if (c == 0 && ocol == 0) continue;
        if (c == 2 && ocol + 1 >= w) continue;
        v = win[r][c];
        sr += v[23:16]; sg += v[15:8]; sb += v[7:0]; n++;
      end
    bw.red = 8'((2 * sr + n) / (2 * n));
    bw.green = 8'((2 * sg + n) / (2 * n));
    bw.blue = 8'((2 * sb + n) / (2 * n));
    bw.last = (orow + 1 >= h) && (ocol + 1 >= w);
    expected_blur.push_back(bw);
    ocol++;
    if (ocol >= w) begin
      ocol = 0;
      orow++;
    end
    if (bw.last) restart_counts();
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got %0h want %0h at output word %0d", what, got, want, n_out);
    errors++;
  endtask

  // driver
  int s_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_blur(pending_words.pop_front());
        n_in++;
        s_gap = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) s_gap = 0;
      end
      if (s_tvalid && !s_tready) begin
      end else if (s_gap > 0) begin
        s_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tuser <= pending_words[0].op;
        s_tdata <= {pending_words[0].blue, pending_words[0].green, pending_words[0].red};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  int m_gap = 0;
  always @(posedge clk) begin
    blur_word_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        n_out++;
        if (m_tlast) n_last++;
        if (expected_blur.size() == 0) begin
          report("unexpected word", {7'd0, m_tlast, m_tdata}, 32'd0);
        end else begin
          want = expected_blur.pop_front();
          if (m_tdata[7:0] !== want.red) report("red", 32'(m_tdata[7:0]), 32'(want.red));
          if (m_tdata[15:8] !== want.green)
            report("green", 32'(m_tdata[15:8]), 32'(want.green));
          if (m_tdata[23:16] !== want.blue)
            report("blue", 32'(m_tdata[23:16]), 32'(want.blue));
          if (m_tlast !== want.last) report("frame_last", 32'(m_tlast), 32'(want.last));
        end
        m_gap = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) m_gap = 0;
      end
      if (hold_off) begin
        m_tready <= 1'b0;
      end else if (m_gap > 0) begin
        m_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else if (pending_words.size() > 0 || expected_blur.size() > 0) idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("watchdog expired, %0d words still expected", expected_blur.size());
        $display("box_blur_3x3_edge_aware verification failed");
        $finish;
      end
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == bbe_pkg::ADDR_WIDTH) cfg_width = data[10:0];
    else if (addr == bbe_pkg::ADDR_HEIGHT) cfg_height = data[12:0];
    restart_counts();
  endtask

  task automatic settle();
    wait (pending_words.size() == 0 && expected_blur.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic push_pix(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    pix_word_t p;
    p.op = bbe_pkg::OP_PIXEL; p.red = r; p.green = g; p.blue = b;
    pending_words.push_back(p);
  endtask

  task automatic push_drain(input int k);
    pix_word_t p;
    p.op = bbe_pkg::OP_DRAIN; p.red = 8'h00; p.green = 8'h00; p.blue = 8'h00;
    repeat (k) pending_words.push_back(p);
  endtask

  task automatic push_rand();
    push_pix($urandom, $urandom, $urandom);
  endtask

  // one frame with a few stray drain words in the pixel phase, then the flush
  task automatic queue_frame(input int unsigned w, input int unsigned h);
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 15) == 0) push_drain(1);
      push_rand();
    end
    for (int i = 0; i <= w; i++) begin
      if ($urandom_range(0, 7) == 0) push_rand();
      else push_drain(1);
    end
  endtask

  task automatic run_frames(input int unsigned w, input int unsigned h, input int k);
    apb_write(bbe_pkg::ADDR_WIDTH, w);
    apb_write(bbe_pkg::ADDR_HEIGHT, h);
    repeat (k) queue_frame(w, h);
    settle();
  endtask

  initial begin
    cfg_width = 1; cfg_height = 1;
    for (int i = 0; i < MAXW; i++) begin
      line_up[i] = '0; line_mid[i] = '0;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) win[r][c] = '0;
    restart_counts();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // reset config 1x1, then directed extremes on 3x3
    push_pix(8'hFF, 8'h00, 8'hFF);
    push_drain(2);
    settle();
    apb_write(bbe_pkg::ADDR_WIDTH, 3);
    apb_write(bbe_pkg::ADDR_HEIGHT, 3);
    push_drain(1);
    push_pix(8'hFF, 8'hFF, 8'hFF); push_pix(8'h00, 8'h00, 8'h00); push_pix(8'hFF, 8'h00, 8'h55);
    push_pix(8'h01, 8'h80, 8'hAA); push_pix(8'hFF, 8'hFF, 8'hFF); push_pix(8'h7F, 8'hFE, 8'h01);
    push_pix(8'h00, 8'hFF, 8'h00); push_pix(8'hFF, 8'hFF, 8'hFF); push_pix(8'h02, 8'h03, 8'h04);
    push_drain(2);
    push_pix(8'h12, 8'h34, 8'h56);
    push_drain(1);
    settle();
    // clamped registers: width 0 and over range, height 0 and over range
    run_frames(0, 0, 2);
    apb_write(bbe_pkg::ADDR_WIDTH, 2047);
    apb_write(bbe_pkg::ADDR_HEIGHT, 1);
    queue_frame(1024, 1);
    settle();
    run_frames(1, 8191, 0);
    run_frames(1, 5, 2);
    // stall test: receiver holds off while the sender keeps going
    apb_write(bbe_pkg::ADDR_WIDTH, 5);
    apb_write(bbe_pkg::ADDR_HEIGHT, 4);
    queue_frame(5, 4);
    hold_off = 1;
    repeat (300) @(posedge clk);
    hold_off = 0;
    settle();
    // random frames, mostly small
    while (n_in < 2400) begin
      run_frames($urandom_range(1, 12), $urandom_range(1, 10), $urandom_range(1, 3));
    end
    run_frames(1, 1, 3);
    $display("%0d input words, %0d blurred words checked, %0d frames completed",
             n_in, n_out, n_last);
    $display("covered clamped sizes, widths 1 to 1024, stray drains and an output stall");
    if (errors == 0) begin
      $display("box_blur_3x3_edge_aware verification clean");
    end else begin
      $display("box_blur_3x3_edge_aware verification failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/bbe_pkg.sv
rtl/bbe_front.sv
rtl/bbe_queue.sv
rtl/bbe_back.sv
rtl/box_blur_3x3_edge_aware.sv
rtl/bbe_check.sv
tb/sv/box_blur_3x3_edge_aware_tb.sv
